### src/bsgu_pkg.sv
`timescale 1ns / 1ps
package bsgu_pkg;
    localparam int COORD_WIDTH = 24;
    localparam int FRAC_BITS = 12;
    localparam logic [2:0] OP_CLIP_FRONT = 3'd0;
    localparam logic [2:0] OP_CLIP_BACK = 3'd1;
    localparam logic [2:0] OP_INC_POINT = 3'd2;
    localparam logic [2:0] OP_INC_SPHERE = 3'd3;
    localparam logic [2:0] OP_INTERSECT = 3'd4;
    localparam logic [2:0] OP_UNION = 3'd5;
endpackage

### src/bsgu_front.sv
`timescale 1ns / 1ps
module bsgu_front #(
    parameter int CW = bsgu_pkg::COORD_WIDTH,
    parameter int FB = bsgu_pkg::FRAC_BITS
) (
    input  logic                 aclk,
    input  logic                 en,
    input  logic [2:0]           op,
    input  logic signed [CW-1:0] ax, ay, az, bx, by, bz, bw,
    input  logic [CW-2:0]        ar,
    output logic [2:0]           op_q,
    output logic                 hit_q,
    output logic [2*CW+1:0]      sq_q,
    output logic [CW-1:0]        r0_q, r1_q,
    output logic signed [CW-1:0] c0x_q, c0y_q, c0z_q,
    output logic signed [CW:0]   dx_q, dy_q, dz_q
);
    localparam int SW = 2*CW+2;
    localparam int DW = 2*CW+FB+4;
    logic signed [CW:0] dx, dy, dz;
    logic [SW-1:0] sq, lim;
    logic [CW-1:0] rb, arw, ra, rbig, rsml;
    logic signed [DW-1:0] dot, rr;
    logic a_big, h;
    always_comb begin
        rb = bw[CW-1] ? '0 : bw;
        arw = {1'b0, ar};
        dx = {bx[CW-1], bx} - {ax[CW-1], ax};
        dy = {by[CW-1], by} - {ay[CW-1], ay};
        dz = {bz[CW-1], bz} - {az[CW-1], az};
        sq = SW'(dx*dx) + SW'(dy*dy) + SW'(dz*dz);
        dot = (DW'(bw) <<< FB) + DW'(bx*ax) + DW'(by*ay) + DW'(bz*az);
        rr = DW'($signed({1'b0, arw})) <<< FB;
        a_big = arw > rb;
        ra = a_big ? arw - rb : '0;
        lim = '0;
        case (op)
            bsgu_pkg::OP_INC_POINT: lim = SW'(arw*arw);
            bsgu_pkg::OP_INC_SPHERE: lim = SW'(ra*ra);
            bsgu_pkg::OP_INTERSECT: lim = SW'((arw+rb)*(arw+rb));
            default: lim = '0;
        endcase
        h = 1'b0;
        case (op)
            bsgu_pkg::OP_CLIP_FRONT: h = dot >= -rr;
            bsgu_pkg::OP_CLIP_BACK: h = dot <= rr;
            bsgu_pkg::OP_INC_POINT: h = sq <= lim;
            bsgu_pkg::OP_INC_SPHERE: h = a_big && sq <= lim;
            bsgu_pkg::OP_INTERSECT: h = sq <= lim;
            default: h = 1'b0;
        endcase
        rbig = a_big ? arw : rb;
        rsml = a_big ? rb : arw;
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            op_q <= op; hit_q <= h; sq_q <= sq; r0_q <= rbig; r1_q <= rsml;
            c0x_q <= a_big ? ax : bx; c0y_q <= a_big ? ay : by; c0z_q <= a_big ? az : bz;
            dx_q <= a_big ? dx : -dx; dy_q <= a_big ? dy : -dy; dz_q <= a_big ? dz : -dz;
        end
    end
endmodule

### src/bsgu_sqrt_cell.sv
`timescale 1ns / 1ps
module bsgu_sqrt_cell #(
    parameter int SW = 50,
    parameter int QW = 26,
    parameter int BIT = 0
) (
    input  logic          aclk,
    input  logic          en,
    input  logic [SW-1:0] v_in,
    input  logic [QW-1:0] q_in,
    output logic [SW-1:0] v_out,
    output logic [QW-1:0] q_out
);
    logic [QW-1:0] c;
    logic [2*QW-1:0] cc;
    always_comb begin
        c = q_in | (QW'(1) << BIT);
        cc = (2*QW)'(c) * (2*QW)'(c);
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            v_out <= v_in;
            q_out <= ((2*QW+SW)'(cc) <= (2*QW+SW)'(v_in)) ? c : q_in;
        end
    end
endmodule

### src/bsgu_div_cell.sv
`timescale 1ns / 1ps
module bsgu_div_cell #(
    parameter int NW = 52,
    parameter int DW = 28
) (
    input  logic          aclk,
    input  logic          en,
    input  logic [NW-1:0] n_in,
    input  logic [DW-1:0] d,
    input  logic [DW:0]   rem_in,
    input  logic [NW-1:0] q_in,
    output logic [NW-1:0] n_out,
    output logic [DW:0]   rem_out,
    output logic [NW-1:0] q_out
);
    logic [DW+1:0] r;
    always_comb r = {rem_in, n_in[NW-1]};
    always_ff @(posedge aclk) begin
        if (en) begin
            n_out <= n_in << 1;
            if (d != '0 && r >= (DW+2)'(d)) begin
                rem_out <= (DW+1)'(r - (DW+2)'(d));
                q_out <= {q_in[NW-2:0], 1'b1};
            end else begin
                rem_out <= (DW+1)'(r);
                q_out <= {q_in[NW-2:0], 1'b0};
            end
        end
    end
endmodule

### src/bounding_sphere_geometry_unit.sv
`timescale 1ns / 1ps
// stages: front register, (COORD_WIDTH+2) root cells, setup register, (2*COORD_WIDTH+4) divide cells, output register
// throughput: one word per cycle while not stalled; every stage is a register cell that moves on when unstalled
// the whole chain stalls only when the output register is full and not taken
// reset: synchronous active-low aresetn clears the valid chain; payload is not reset
module bounding_sphere_geometry_unit #(
    parameter int COORD_WIDTH = bsgu_pkg::COORD_WIDTH,
    parameter int FRAC_BITS = bsgu_pkg::FRAC_BITS
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    // operation, a_x, a_y, a_z, a_radius, b_x, b_y, b_z, b_w
    input  logic [((8*COORD_WIDTH+2+7)/8)*8-1:0] s_tdata,
    output logic m_tvalid,
    input  logic m_tready,
    // hit, out_x, out_y, out_z, out_radius
    output logic [((4*COORD_WIDTH+7)/8)*8-1:0] m_tdata
);
    localparam int CW = COORD_WIDTH;
    localparam int SW = 2*CW+2;
    localparam int QW = CW+2;
    localparam int NW = 2*CW+4;
    localparam int DV = CW+4;
    localparam int NS = QW + 1 + NW + 1;
    logic en;
    logic [NS-1:0] vld_reg;
    logic out_valid_reg;
    assign en = !out_valid_reg || m_tready;
    assign s_tready = en;
    assign m_tvalid = out_valid_reg;

    logic [2:0] op_q; logic hit_q; logic [SW-1:0] sq_q;
    logic [CW-1:0] r0_q, r1_q;
    logic signed [CW-1:0] c0x_q, c0y_q, c0z_q;
    logic signed [CW:0] dx_q, dy_q, dz_q;
    bsgu_front #(.CW(CW), .FB(FRAC_BITS)) u_front (
        .aclk(aclk), .en(en), .op(s_tdata[2:0]),
        .ax(s_tdata[3+:CW]), .ay(s_tdata[3+CW+:CW]), .az(s_tdata[3+2*CW+:CW]),
        .ar(s_tdata[3+3*CW+:CW-1]),
        .bx(s_tdata[2+4*CW+:CW]), .by(s_tdata[2+5*CW+:CW]), .bz(s_tdata[2+6*CW+:CW]),
        .bw(s_tdata[2+7*CW+:CW]),
        .op_q(op_q), .hit_q(hit_q), .sq_q(sq_q), .r0_q(r0_q), .r1_q(r1_q),
        .c0x_q(c0x_q), .c0y_q(c0y_q), .c0z_q(c0z_q), .dx_q(dx_q), .dy_q(dy_q), .dz_q(dz_q));

    typedef struct packed {
        logic [2:0] op; logic hit; logic [CW-1:0] r0, r1;
        logic signed [CW-1:0] c0x, c0y, c0z; logic signed [CW:0] dx, dy, dz;
    } side_t;
    side_t sside [QW+1];
    logic [SW-1:0] sv [QW+1];
    logic [QW-1:0] sq [QW+1];
    assign sside[0] = '{op_q, hit_q, r0_q, r1_q, c0x_q, c0y_q, c0z_q, dx_q, dy_q, dz_q};
    assign sv[0] = sq_q;
    assign sq[0] = '0;
    for (genvar g = 0; g < QW; g++) begin : g_sqrt
        bsgu_sqrt_cell #(.SW(SW), .QW(QW), .BIT(QW-1-g)) u_cell (
            .aclk(aclk), .en(en), .v_in(sv[g]), .q_in(sq[g]),
            .v_out(sv[g+1]), .q_out(sq[g+1]));
        always_ff @(posedge aclk) if (en) sside[g+1] <= sside[g];
    end

    // setup stage for the center divide
    side_t p_reg; logic [QW-1:0] dist_reg; logic grow_reg;
    logic [DV-1:0] den_reg; logic [QW-1:0] k_reg; logic [CW:0] rad_reg;
    logic [QW:0] radsum;
    logic [QW-1:0] dist_w;
    always_comb begin
        dist_w = sq[QW];
        radsum = (QW+1)'(sside[QW].r0) + (QW+1)'(dist_w) + (QW+1)'(sside[QW].r1);
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            p_reg <= sside[QW];
            dist_reg <= dist_w;
            grow_reg <= (QW+1)'(dist_w) > (QW+1)'(sside[QW].r0 - sside[QW].r1);
            den_reg <= DV'({dist_w, 1'b0});
            k_reg <= QW'((QW+1)'(dist_w) + (QW+1)'(sside[QW].r1) - (QW+1)'(sside[QW].r0));
            rad_reg <= (radsum[QW:1] > (QW)'({1'b0, {(CW-1){1'b1}}}))
                ? {2'b0, {(CW-1){1'b1}}} : (CW+1)'(radsum[QW:1]);
        end
    end

    typedef struct packed {
        logic [2:0] op; logic hit; logic grow; logic [CW-1:0] r0;
        logic signed [CW-1:0] c0x, c0y, c0z; logic nx, ny, nz; logic [CW:0] rad;
    } dside_t;
    dside_t dside [NW+1];
    logic [NW-1:0] dn [3][NW+1];
    logic [NW-1:0] dq [3][NW+1];
    logic [DV:0] dr [3][NW+1];
    logic [DV-1:0] dd [NW+1];
    logic [CW:0] mx, my, mz;
    always_comb begin
        mx = p_reg.dx[CW] ? -p_reg.dx : p_reg.dx;
        my = p_reg.dy[CW] ? -p_reg.dy : p_reg.dy;
        mz = p_reg.dz[CW] ? -p_reg.dz : p_reg.dz;
    end
    assign dside[0] = '{p_reg.op, p_reg.hit, grow_reg, p_reg.r0, p_reg.c0x, p_reg.c0y,
                        p_reg.c0z, p_reg.dx[CW], p_reg.dy[CW], p_reg.dz[CW], rad_reg};
    assign dn[0][0] = NW'(mx * k_reg);
    assign dn[1][0] = NW'(my * k_reg);
    assign dn[2][0] = NW'(mz * k_reg);
    assign dd[0] = den_reg;
    for (genvar a = 0; a < 3; a++) begin : g_ax
        assign dq[a][0] = '0;
        assign dr[a][0] = '0;
        for (genvar g = 0; g < NW; g++) begin : g_div
            bsgu_div_cell #(.NW(NW), .DW(DV)) u_cell (
                .aclk(aclk), .en(en), .n_in(dn[a][g]), .d(dd[g]), .rem_in(dr[a][g]),
                .q_in(dq[a][g]), .n_out(dn[a][g+1]), .rem_out(dr[a][g+1]),
                .q_out(dq[a][g+1]));
        end
    end
    for (genvar g = 0; g < NW; g++) begin : g_dsd
        always_ff @(posedge aclk) if (en) begin
            dside[g+1] <= dside[g];
            dd[g+1] <= dd[g];
        end
    end

    dside_t e;
    logic [CW-1:0] ox, oy, oz, orad;
    always_comb begin
        e = dside[NW];
        ox = '0; oy = '0; oz = '0; orad = '0;
        if (e.op == bsgu_pkg::OP_UNION) begin
            if (e.grow) begin
                ox = e.c0x + (e.nx ? -CW'(dq[0][NW]) : CW'(dq[0][NW]));
                oy = e.c0y + (e.ny ? -CW'(dq[1][NW]) : CW'(dq[1][NW]));
                oz = e.c0z + (e.nz ? -CW'(dq[2][NW]) : CW'(dq[2][NW]));
                orad = CW'(e.rad);
            end else begin
                ox = e.c0x; oy = e.c0y; oz = e.c0z; orad = e.r0;
            end
        end
    end

    logic [4*CW-1:0] res_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
            out_valid_reg <= 1'b0;
        end else if (en) begin
            vld_reg <= {vld_reg[NS-2:0], s_tvalid};
            out_valid_reg <= vld_reg[NS-1];
        end
        if (en) res_reg <= {orad[CW-2:0], oz, oy, ox, e.hit && e.op != bsgu_pkg::OP_UNION};
    end
    assign m_tdata = {{(((4*CW+7)/8)*8-4*CW){1'b0}}, res_reg};
endmodule

### src/bsgu_checker.sv
`timescale 1ns / 1ps
module bsgu_sva (
    input logic aclk,
    input logic aresetn,
    input logic s_tvalid,
    input logic s_tready,
    input logic m_tvalid,
    input logic m_tready,
    input logic [95:0] m_tdata
);
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("stall");
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready) else $error("ready");
    a_rst: assert property (@(posedge aclk) !aresetn |=> !m_tvalid) else $error("reset");
    a_union_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[0] |-> m_tdata[95:1] == '0) else $error("hit");
endmodule
bind bounding_sphere_geometry_unit bsgu_sva u_chk (
    .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata));
